/* sv/psar_pkg.sv */
// Shared types, constants and register codes for the parabolic SAR block.
`timescale 1ns / 1ps

package psar_pkg;

   // Field widths
   localparam int PRICE_W   = 32;
   localparam int ACCEL_W   = 16;
   localparam int WIN_W     = 8;
   localparam int TOL_REL_W = 16;
   localparam int TOL_ABS_W = 10;

   // Relative tolerance is in units of 2^-32
   localparam int TOL_SHIFT = 32;

   // Default fraction bits of the acceleration factor
   localparam int ACCEL_FRAC_DEF = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_SEED_WINDOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEL_START  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEL_STEP   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEL_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TOL_RELATIVE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TOL_ABSOLUTE = 3'd5;

   // Register reset values
   localparam logic [WIN_W-1:0]     SEED_WINDOW_RST  = 8'd1;
   localparam logic [ACCEL_W-1:0]   ACCEL_START_RST  = 16'd1311;
   localparam logic [ACCEL_W-1:0]   ACCEL_STEP_RST   = 16'd1311;
   localparam logic [ACCEL_W-1:0]   ACCEL_LIMIT_RST  = 16'd13107;
   localparam logic [TOL_REL_W-1:0] TOL_RELATIVE_RST = 16'd0;
   localparam logic [TOL_ABS_W-1:0] TOL_ABSOLUTE_RST = 10'd0;

   // Input bar
   typedef struct packed {
      logic                      series_start;
      logic signed [PRICE_W-1:0] bar_high;
      logic signed [PRICE_W-1:0] bar_low;
   } req_type;

   // Result
   typedef struct packed {
      logic signed [PRICE_W-1:0] sar_price;
      logic                      sar_valid;
      logic                      trend_falling;
   } rsp_type;

   // Configuration registers
   typedef struct packed {
      logic [WIN_W-1:0]     seed_window;
      logic [ACCEL_W-1:0]   accel_start;
      logic [ACCEL_W-1:0]   accel_step;
      logic [ACCEL_W-1:0]   accel_limit;
      logic [TOL_REL_W-1:0] tol_relative;
      logic [TOL_ABS_W-1:0] tol_absolute;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // take the bar, multiply |low| by the relative tolerance
      logic tol_hi;    // register tol(low), multiply |high|
      logic decide;    // trend, extreme and acceleration update
      logic project;   // multiply |delta| by the acceleration
      logic load;      // finish the SAR and load the result register
   } cmd_type;

endpackage

/* sv/psar_csr.sv */
// Configuration registers of the parabolic SAR block.
`timescale 1ns / 1ps

module psar_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [psar_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psar_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output psar_pkg::cfg_type                  cfg
);

   psar_pkg::cfg_type cfg_ff, cfg_in;

   // Write decode; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            psar_pkg::REG_SEED_WINDOW:
               cfg_in.seed_window = csr_wdata[psar_pkg::WIN_W-1:0];
            psar_pkg::REG_ACCEL_START:
               cfg_in.accel_start = csr_wdata[psar_pkg::ACCEL_W-1:0];
            psar_pkg::REG_ACCEL_STEP:
               cfg_in.accel_step = csr_wdata[psar_pkg::ACCEL_W-1:0];
            psar_pkg::REG_ACCEL_LIMIT:
               cfg_in.accel_limit = csr_wdata[psar_pkg::ACCEL_W-1:0];
            psar_pkg::REG_TOL_RELATIVE:
               cfg_in.tol_relative = csr_wdata[psar_pkg::TOL_REL_W-1:0];
            psar_pkg::REG_TOL_ABSOLUTE:
               cfg_in.tol_absolute = csr_wdata[psar_pkg::TOL_ABS_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed_window  <= psar_pkg::SEED_WINDOW_RST;
         cfg_ff.accel_start  <= psar_pkg::ACCEL_START_RST;
         cfg_ff.accel_step   <= psar_pkg::ACCEL_STEP_RST;
         cfg_ff.accel_limit  <= psar_pkg::ACCEL_LIMIT_RST;
         cfg_ff.tol_relative <= psar_pkg::TOL_RELATIVE_RST;
         cfg_ff.tol_absolute <= psar_pkg::TOL_ABSOLUTE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/psar_ctrl.sv */
// Sequencing controller of the parabolic SAR block.
`timescale 1ns / 1ps

module psar_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output psar_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_TOL_HI  = 3'd1;
   localparam logic [2:0] ST_DECIDE  = 3'd2;
   localparam logic [2:0] ST_PROJECT = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Result register may take a new value when empty or draining now
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_TOL_HI;
            end
         end
         ST_TOL_HI: begin
            cmd.tol_hi = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_PROJECT;
         end
         ST_PROJECT: begin
            cmd.project = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid flag
   always_comb begin
      priority if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/psar_datapath.sv */
// Datapath of the parabolic SAR block: shared multiplier, trend state, result register.
`timescale 1ns / 1ps

module psar_datapath #(
   parameter int ACCEL_FRAC_BITS = psar_pkg::ACCEL_FRAC_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  psar_pkg::cmd_type cmd,
   input  psar_pkg::cfg_type cfg,
   input  psar_pkg::req_type req_data,
   output psar_pkg::rsp_type rsp_data
);

   localparam int PW     = psar_pkg::PRICE_W;
   localparam int AW     = psar_pkg::ACCEL_W;
   localparam int WW     = psar_pkg::WIN_W;
   localparam int TS     = psar_pkg::TOL_SHIFT;
   localparam int MAG_W  = PW + 1;
   localparam int PROD_W = MAG_W + AW;
   localparam int WIDE_W = PW + 4 + ((AW > ACCEL_FRAC_BITS) ? (AW - ACCEL_FRAC_BITS) : 0);

   localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

   // Sign extension of a price to the compare width
   function automatic logic signed [WIDE_W-1:0] widen(input logic signed [PW-1:0] v);
      widen = {{(WIDE_W-PW){v[PW-1]}}, v};
   endfunction

   // Magnitude of a price
   function automatic logic [MAG_W-1:0] mag_of(input logic signed [PW-1:0] v);
      logic [MAG_W-1:0] e;
      e = {v[PW-1], v};
      mag_of = v[PW-1] ? (~e + 1'b1) : e;
   endfunction

   // ceil(product / 2^32) + absolute tolerance
   function automatic logic signed [WIDE_W-1:0] tol_of(
      input logic [PROD_W-1:0]              p,
      input logic [psar_pkg::TOL_ABS_W-1:0] tabs
   );
      logic [WIDE_W-1:0] u;
      u = WIDE_W'(p[PROD_W-1:TS]) + WIDE_W'(|p[TS-1:0]) + WIDE_W'(tabs);
      tol_of = signed'(u);
   endfunction

   // Captured bar
   logic signed [PW-1:0] hi_ff, lo_ff;
   logic                 start_ff;

   // Shared multiplier
   logic [MAG_W-1:0]  mul_a;
   logic [AW-1:0]     mul_b;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // Trend state
   logic                 falling_ff, falling_in;
   logic signed [PW-1:0] extreme_ff, extreme_in;
   logic [AW-1:0]        accel_ff, accel_in;
   logic signed [PW-1:0] last_sar_ff;
   logic signed [PW-1:0] last_high_ff, last_low_ff;
   logic signed [PW-1:0] seed_min_ff, seed_min_in;
   logic [WW-1:0]        bar_index_ff, bar_index_in;

   // Work registers between steps
   logic signed [WIDE_W-1:0] tol_lo_ff;
   logic                     seeding_ff, seed_hit_ff, use_max_ff, dneg_ff;
   logic signed [PW-1:0]     bound_ff, bound_in;
   logic                     use_max_in;
   logic [MAG_W-1:0]         dmag_ff, dmag_in;
   logic                     dneg_in;
   psar_pkg::rsp_type        rsp_ff;

   // Decide step signals
   logic [WW-1:0]            idx, win;
   logic                     seeding, seed_hit;
   logic signed [WIDE_W-1:0] lo_w, hi_w, prev_w, ext_w, seed_w, tol_hi;
   logic [AW:0]              grow_sum;
   logic [AW-1:0]            accel_grown;
   logic signed [PW-1:0]     base, max_hi, min_lo;
   logic signed [MAG_W-1:0]  delta;

   // Finish step signals
   logic [WIDE_W-1:0]        q;
   logic signed [WIDE_W-1:0] cand, bound_w, res;
   logic signed [PW-1:0]     sat, fin_sar;
   logic                     fin_valid;

   // Multiplier operand select
   always_comb begin
      mul_a = mag_of(hi_ff);
      mul_b = cfg.tol_relative;
      priority if (cmd.capture) begin
         mul_a = mag_of(req_data.bar_low);
      end else if (cmd.project) begin
         mul_a = dmag_ff;
         mul_b = accel_ff;
      end
   end

   assign prod_in = {{AW{1'b0}}, mul_a} * {{MAG_W{1'b0}}, mul_b};

   // Decide: seed scan, reversal test, new extreme and acceleration
   assign idx     = start_ff ? '0 : bar_index_ff;
   assign win     = (cfg.seed_window == '0) ? WW'(1) : cfg.seed_window;
   assign seeding = (idx < win);
   assign seed_hit = (idx == (win - WW'(1)));
   assign lo_w    = widen(lo_ff);
   assign hi_w    = widen(hi_ff);
   assign prev_w  = widen(last_sar_ff);
   assign ext_w   = widen(extreme_ff);
   assign seed_w  = widen(seed_min_ff);
   assign tol_hi  = tol_of(prod_ff, cfg.tol_absolute);

   assign grow_sum    = {1'b0, accel_ff} + {1'b0, cfg.accel_step};
   assign accel_grown = (grow_sum < {1'b0, cfg.accel_limit}) ? grow_sum[AW-1:0]
                                                             : cfg.accel_limit;
   assign max_hi = (hi_ff > last_high_ff) ? hi_ff : last_high_ff;
   assign min_lo = (lo_ff < last_low_ff) ? lo_ff : last_low_ff;

   always_comb begin
      seed_min_in = seed_min_ff;
      falling_in  = falling_ff;
      extreme_in  = extreme_ff;
      accel_in    = accel_ff;
      bound_in    = min_lo;
      use_max_in  = 1'b0;
      base        = last_sar_ff;

      // Seed low: a later low replaces the minimum only when clearly below
      priority if (idx == '0) begin
         seed_min_in = lo_ff;
      end else if (seeding && ((seed_w - lo_w) >= tol_lo_ff)) begin
         seed_min_in = lo_ff;
      end

      if (idx == '0) begin
         falling_in = 1'b0;
         extreme_in = hi_ff;
         accel_in   = cfg.accel_start;
      end

      if (!seeding) begin
         if (!falling_ff) begin
            if ((prev_w - lo_w) >= tol_lo_ff) begin
               // rising trend reverses
               falling_in = 1'b1;
               extreme_in = lo_ff;
               accel_in   = cfg.accel_start;
               bound_in   = max_hi;
               use_max_in = 1'b1;
               base       = extreme_ff;
            end else if ((hi_w - ext_w) >= tol_hi) begin
               extreme_in = hi_ff;
               accel_in   = accel_grown;
            end
         end else begin
            if ((hi_w - prev_w) >= tol_hi) begin
               // falling trend reverses
               falling_in = 1'b0;
               extreme_in = hi_ff;
               accel_in   = cfg.accel_start;
               base       = extreme_ff;
            end else begin
               bound_in   = max_hi;
               use_max_in = 1'b1;
               if ((ext_w - lo_w) >= tol_lo_ff) begin
                  extreme_in = lo_ff;
                  accel_in   = accel_grown;
               end
            end
         end
      end
   end

   // Step toward the extreme, split into sign and magnitude for the multiplier
   assign delta   = {extreme_in[PW-1], extreme_in} - {base[PW-1], base};
   assign dneg_in = delta[MAG_W-1];
   assign dmag_in = dneg_in ? MAG_W'(-delta) : MAG_W'(delta);

   assign bar_index_in = (idx < {WW{1'b1}}) ? (idx + WW'(1)) : idx;

   // Finish: round half away from zero, bound by bar extremes, saturate
   assign q = WIDE_W'(prod_ff >> ACCEL_FRAC_BITS) + WIDE_W'(prod_ff[ACCEL_FRAC_BITS-1]);
   assign cand    = dneg_ff ? (prev_w - signed'(q)) : (prev_w + signed'(q));
   assign bound_w = widen(bound_ff);

   always_comb begin
      if (use_max_ff) begin
         res = (cand > bound_w) ? cand : bound_w;
      end else begin
         res = (cand < bound_w) ? cand : bound_w;
      end
      priority if (res > widen(PMAX)) begin
         sat = PMAX;
      end else if (res < widen(PMIN)) begin
         sat = PMIN;
      end else begin
         sat = res[PW-1:0];
      end
   end

   assign fin_valid = !seeding_ff || seed_hit_ff;
   assign fin_sar   = seeding_ff ? (seed_hit_ff ? seed_min_ff : '0) : sat;

   // Trend state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         falling_ff   <= 1'b0;
         extreme_ff   <= '0;
         accel_ff     <= psar_pkg::ACCEL_START_RST;
         last_sar_ff  <= '0;
         last_high_ff <= '0;
         last_low_ff  <= '0;
         seed_min_ff  <= '0;
         bar_index_ff <= '0;
      end else begin
         if (cmd.decide) begin
            falling_ff   <= falling_in;
            extreme_ff   <= extreme_in;
            accel_ff     <= accel_in;
            seed_min_ff  <= seed_min_in;
            last_high_ff <= hi_ff;
            last_low_ff  <= lo_ff;
            bar_index_ff <= bar_index_in;
         end
         if (cmd.load && fin_valid) begin
            last_sar_ff <= fin_sar;
         end
      end
   end

   // Payload and work registers; the product holds while the finish step waits
   always_ff @(posedge clock) begin
      if (cmd.capture || cmd.tol_hi || cmd.project) begin
         prod_ff <= prod_in;
      end
      if (cmd.capture) begin
         hi_ff    <= req_data.bar_high;
         lo_ff    <= req_data.bar_low;
         start_ff <= req_data.series_start;
      end
      if (cmd.tol_hi) begin
         tol_lo_ff <= tol_of(prod_ff, cfg.tol_absolute);
      end
      if (cmd.decide) begin
         seeding_ff  <= seeding;
         seed_hit_ff <= seed_hit;
         bound_ff    <= bound_in;
         use_max_ff  <= use_max_in;
         dmag_ff     <= dmag_in;
         dneg_ff     <= dneg_in;
      end
      if (cmd.load) begin
         rsp_ff.sar_price     <= fin_sar;
         rsp_ff.sar_valid     <= fin_valid;
         rsp_ff.trend_falling <= falling_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* sv/parabolic_stop_and_reverse_unit.sv */
// Top level of the parabolic stop-and-reverse block.
//
// Usage:
//   req_*  : one price bar per transfer (series_start, bar_high, bar_low).
//   rsp_*  : one result per bar (sar_price, sar_valid, trend_falling), in order.
//   csr_*  : register writes, one per cycle with csr_write_en high; write
//            only while no bar is in flight.
// Timing:
//   A bar is taken only when the block is idle, so the next bar is not
//   accepted until the last one has loaded its result; req_ready rises in
//   the same cycle that the result appears on rsp_valid. The single shared
//   multiplier works in turn on the tolerance of the low, the tolerance of
//   the high, then the projected step, each through the same unit; the decide
//   step comes before the projection and the finish step after it.
// Stall:
//   A finished result waits in the output register; the next bar is still
//   taken and worked on, and its finish step holds until the register drains.
// Reset:
//   Synchronous. Configuration and trend state registers return to their defaults,
//   the bar count restarts, no result is pending and req_ready is high in the next cycle.
`timescale 1ns / 1ps

module parabolic_stop_and_reverse_unit #(
   parameter int ACCEL_FRAC_BITS = psar_pkg::ACCEL_FRAC_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  psar_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output psar_pkg::rsp_type                rsp_data,
   input  logic                             csr_write_en,
   input  logic [psar_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psar_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   psar_pkg::cfg_type cfg;
   psar_pkg::cmd_type cmd;

   psar_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   psar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   psar_datapath #(
      .ACCEL_FRAC_BITS (ACCEL_FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

/* sv/psar_checker.sv */
// Port-level checks of the parabolic SAR block and their bind to the top level.
`timescale 1ns / 1ps

module psar_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input psar_pkg::rsp_type rsp_data
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // One bar at a time: no new transfer while the bar is in the datapath
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("bar taken while another is in progress");

   // A result is presented on rsp_valid once a transferred bar has run through its steps
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##5 rsp_valid)
      else $error("no result after bar transfer");

   // Reset leaves the block empty and ready
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind parabolic_stop_and_reverse_unit psar_checker u_psar_checker (.*);
